// ===== design/b2d_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// Holds the digit-multiple table and the controller/datapath interface structs.
// No dependencies.
package b2d_pkg;

  // Number of decimal digits a 32-bit unsigned value can need
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned POS_W      = $clog2(NUM_DIGITS);
  localparam int unsigned DIGIT_W    = 4;
  // Wide enough for nine times the largest power of ten
  localparam int unsigned MULT_W     = 34;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef logic [NUM_DIGITS-1:0][9:0][MULT_W-1:0] mult_table_t;

  // Entry [pos][j] holds j * 10**pos, worked out at elaboration
  function automatic mult_table_t build_mult_table();
    mult_table_t tbl;
    logic [63:0] pw;
    pw = 64'd1;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      for (int j = 0; j < 10; j++) begin
        tbl[p][j] = MULT_W'(pw * 64'(j));
      end
      pw = pw * 64'd10;
    end
    return tbl;
  endfunction

  localparam mult_table_t MULT_TABLE = build_mult_table();

  // Controller state
  typedef enum logic {
    ST_IDLE,
    ST_CONVERT
  } b2d_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } b2d_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_digit;
  } b2d_status_t;

endpackage

// ===== design/b2d_ctrl.sv =====
// Controller for the binary to decimal ASCII converter.
// Sequences load and per-digit step commands; depends on b2d_pkg.
module b2d_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  b2d_pkg::b2d_status_t status,
  output b2d_pkg::b2d_cmd_t    cmd
);
  import b2d_pkg::*;

  b2d_state_t state_r;
  b2d_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (status.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/b2d_dp.sv =====
// Datapath for the binary to decimal ASCII converter.
// Extracts one decimal digit per step by compare and subtract; depends on b2d_pkg.
module b2d_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  b2d_pkg::b2d_cmd_t            cmd,
  output b2d_pkg::b2d_status_t         status,
  input  logic [b2d_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_strobe,
  output logic [b2d_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                         out_last_char
);
  import b2d_pkg::*;

  logic [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]   pos_r;
  logic               started_r;
  logic               strobe_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;

  logic [DIGIT_W-1:0] digit;
  logic [MULT_W-1:0]  value_ext;
  logic [VALUE_W-1:0] remainder;
  logic               emit;

  // Pick the largest multiple of the current power of ten that fits
  always_comb begin
    value_ext = {{(MULT_W-VALUE_W){1'b0}}, value_r};
    digit     = '0;
    for (int j = 1; j < 10; j++) begin
      if (value_ext >= MULT_TABLE[pos_r][j]) begin
        digit = DIGIT_W'(j);
      end
    end
    remainder = VALUE_W'(value_ext - MULT_TABLE[pos_r][digit]);
  end

  // Suppress leading zeros but always emit the units digit
  assign emit              = (digit != '0) || started_r || (pos_r == '0);
  assign status.last_digit = (pos_r == '0);

  // Working value and digit position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      pos_r   <= POS_W'(NUM_DIGITS - 1);
    end else if (cmd.step) begin
      value_r <= remainder;
      pos_r   <= pos_r - POS_W'(1);
    end
  end

  // Leading-zero tracking and output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= cmd.step && emit;
      if (cmd.load) begin
        started_r <= 1'b0;
      end else if (cmd.step && digit != '0) begin
        started_r <= 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      char_r <= ASCII_ZERO + CHAR_W'(digit);
      last_r <= (pos_r == '0);
    end
  end

  assign out_strobe     = strobe_r;
  assign out_digit_char = char_r;
  assign out_last_char  = last_r;

endmodule

// ===== design/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Joins b2d_ctrl and b2d_dp; depends on b2d_pkg.
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+--------------------------
//   input   | in_value                                 | start high, busy low
//   result  | out_digit_char, out_last_char            | out_strobe, one cycle
//
// A value takes one step per power of ten in the digit loop, and the next start
// is taken only once the controller is back in idle.
// Characters leave in the cycle after their step; leading zero steps emit nothing.
// rst_n is synchronous and clears the controller and the output strobe.
// The receiver cannot stall; every strobed character is taken as it appears.
module binary_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [b2d_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_strobe,
  output logic [b2d_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                         out_last_char
);
  import b2d_pkg::*;

  b2d_cmd_t    cmd;
  b2d_status_t status;

  b2d_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  b2d_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last_char  (out_last_char)
  );

`ifndef SYNTHESIS
  // A character only follows a step cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("character emitted without a conversion step");

  // Nothing follows the final character of a run in the next cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_char) |=> !out_strobe)
    else $error("character right after end of run");

  // An accepted transaction starts conversion
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start conversion");

  // Emitted characters are decimal digits
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_digit_char >= 6'd48 && out_digit_char <= 6'd57))
    else $error("character outside digit range");
`endif

endmodule
